FILE: hdl/nfcp_pkg.sv
// Shared types and codes for the NFC response frame parser.
`default_nettype none

package nfcp_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_INVALID = 2'd2,
        ST_NOSPACE = 2'd3
    } status_t;

    localparam logic [1:0] CFG_SENT_COMMAND   = 2'd0;
    localparam logic [1:0] CFG_MAX_PAYLOAD    = 2'd1;
    localparam logic [1:0] CFG_DIRECTION_CODE = 2'd2;

    localparam logic [7:0] RST_SENT_COMMAND   = 8'd0;
    localparam logic [7:0] RST_MAX_PAYLOAD    = 8'd64;
    localparam logic [7:0] RST_DIRECTION_CODE = 8'd213;

    localparam logic [7:0] PREAMBLE_LAST = 8'hFF;
    localparam logic [7:0] MIN_LENGTH    = 8'd2;

    typedef struct packed {
        logic [7:0] sent_command;
        logic [7:0] max_payload;
        logic [7:0] direction_code;
    } nfcp_cfg_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_status;
        status_t    status;
        logic [7:0] frame_length;
    } nfcp_result_t;

endpackage

`default_nettype wire

FILE: hdl/nfcp_cfg_regs.sv
// Configuration register file: command, payload limit and direction code.
`default_nettype none

module nfcp_cfg_regs
    import nfcp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output nfcp_cfg_t       cfg
);

    nfcp_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sent_command   <= RST_SENT_COMMAND;
            cfg_reg.max_payload    <= RST_MAX_PAYLOAD;
            cfg_reg.direction_code <= RST_DIRECTION_CODE;
        end else if (cfg_valid) begin
            // index beyond the list is dropped
            unique case (cfg_index)
                CFG_SENT_COMMAND:   cfg_reg.sent_command   <= cfg_data;
                CFG_MAX_PAYLOAD:    cfg_reg.max_payload    <= cfg_data;
                CFG_DIRECTION_CODE: cfg_reg.direction_code <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/nfcp_parser.sv
// Frame state machine: one byte or timeout per step, emits payload or status.
`default_nettype none

module nfcp_parser
    import nfcp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [7:0] rx_byte,
    input  wire logic       timed_out,
    input  wire nfcp_cfg_t  cfg,
    output logic            res_valid,
    output nfcp_result_t    res
);

    typedef enum logic [3:0] {
        PH_PRE0    = 4'd0,
        PH_PRE1    = 4'd1,
        PH_PRE2    = 4'd2,
        PH_LEN     = 4'd3,
        PH_LCS     = 4'd4,
        PH_TFI     = 4'd5,
        PH_CMD     = 4'd6,
        PH_DATA    = 4'd7,
        PH_DCS     = 4'd8,
        PH_POST    = 4'd9,
        PH_CMD_BAD = 4'd10
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] length_byte_reg, length_byte_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic [7:0] pre_or;
    logic [7:0] lcs_sum;
    logic [7:0] payload_len;
    logic [7:0] cmd_expect;
    logic [7:0] sum_plus;
    logic [7:0] rem_minus;
    logic       status_hit;
    status_t    status_code;
    logic [7:0] status_len;

    assign pre_or      = running_sum_reg | (rx_byte ^ PREAMBLE_LAST);
    assign lcs_sum     = length_byte_reg + rx_byte;
    assign payload_len = length_byte_reg - MIN_LENGTH;
    assign cmd_expect  = cfg.sent_command + 8'd1;
    assign sum_plus    = running_sum_reg + rx_byte;
    assign rem_minus   = remaining_reg - 8'd1;

    always_comb begin
        phase_next       = phase_reg;
        length_byte_next = length_byte_reg;
        remaining_next   = remaining_reg;
        running_sum_next = running_sum_reg;
        status_hit       = 1'b0;
        status_code      = ST_OK;
        status_len       = 8'd0;
        res_valid        = 1'b0;
        res              = '0;

        if (timed_out) begin
            status_hit  = 1'b1;
            status_code = ST_TIMEOUT;
        end else begin
            unique case (phase_reg)
                PH_PRE0: begin
                    running_sum_next = rx_byte;
                    phase_next       = PH_PRE1;
                end
                PH_PRE1: begin
                    running_sum_next = running_sum_reg | rx_byte;
                    phase_next       = PH_PRE2;
                end
                PH_PRE2: begin
                    if (pre_or != 8'd0) begin
                        status_hit  = 1'b1;
                        status_code = ST_INVALID;
                    end else begin
                        running_sum_next = 8'd0;
                        phase_next       = PH_LEN;
                    end
                end
                PH_LEN: begin
                    length_byte_next = rx_byte;
                    phase_next       = PH_LCS;
                end
                PH_LCS: begin
                    if (lcs_sum != 8'd0 || length_byte_reg < MIN_LENGTH) begin
                        status_hit  = 1'b1;
                        status_code = ST_INVALID;
                    end else if (payload_len > cfg.max_payload) begin
                        status_hit  = 1'b1;
                        status_code = ST_NOSPACE;
                    end else begin
                        remaining_next = payload_len;
                        phase_next     = PH_TFI;
                    end
                end
                PH_TFI: begin
                    phase_next       = (rx_byte == cfg.direction_code) ? PH_CMD : PH_CMD_BAD;
                    running_sum_next = rx_byte;
                end
                PH_CMD_BAD: begin
                    status_hit  = 1'b1;
                    status_code = ST_INVALID;
                end
                PH_CMD: begin
                    if (rx_byte != cmd_expect) begin
                        status_hit  = 1'b1;
                        status_code = ST_INVALID;
                    end else begin
                        running_sum_next = sum_plus;
                        phase_next       = (remaining_reg == 8'd0) ? PH_DCS : PH_DATA;
                    end
                end
                PH_DATA: begin
                    running_sum_next = sum_plus;
                    remaining_next   = rem_minus;
                    if (rem_minus == 8'd0) begin
                        phase_next = PH_DCS;
                    end
                    res_valid        = 1'b1;
                    res.payload_byte = rx_byte;
                end
                PH_DCS: begin
                    running_sum_next = sum_plus;
                    phase_next       = PH_POST;
                end
                PH_POST: begin
                    status_hit = 1'b1;
                    if (running_sum_reg != 8'd0 || rx_byte != 8'd0) begin
                        status_code = ST_INVALID;
                    end else begin
                        status_code = ST_OK;
                        status_len  = payload_len;
                    end
                end
                default: begin
                    phase_next       = PH_PRE0;
                    length_byte_next = 8'd0;
                    remaining_next   = 8'd0;
                    running_sum_next = 8'd0;
                end
            endcase
        end

        // any status ends the frame: back to hunting
        if (status_hit) begin
            phase_next       = PH_PRE0;
            length_byte_next = 8'd0;
            remaining_next   = 8'd0;
            running_sum_next = 8'd0;
            res_valid        = 1'b1;
            res.is_status    = 1'b1;
            res.status       = status_code;
            res.frame_length = status_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_PRE0;
            length_byte_reg <= 8'd0;
            remaining_reg   <= 8'd0;
            running_sum_reg <= 8'd0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            length_byte_reg <= length_byte_next;
            remaining_reg   <= remaining_next;
            running_sum_reg <= running_sum_next;
        end
    end

    a_status_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res_valid && res.is_status |=> phase_reg == PH_PRE0)
        else $error("parser did not return to hunting after a status");

    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !(phase_reg == PH_DATA && remaining_reg == 8'd0))
        else $error("payload phase entered with no bytes left");

    a_payload_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res.is_status |-> phase_reg == PH_DATA && !timed_out)
        else $error("payload beat outside the payload phase");

    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && phase_reg == PH_LCS && !res_valid |=> remaining_reg <= cfg.max_payload)
        else $error("accepted length exceeds the payload limit");

endmodule

`default_nettype wire

FILE: hdl/nfcp_out_reg.sv
// Result register on the master side of the stream.
`default_nettype none

module nfcp_out_reg
    import nfcp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  wire nfcp_result_t  res,
    output logic               can_load,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,
    output logic               m_tuser
);

    logic         valid_reg;
    nfcp_result_t res_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.frame_length, res_reg.status, res_reg.payload_byte};
    assign m_tuser  = res_reg.is_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/nfc_response_frame_parser.sv
// Top level: input register, config registers, frame parser and result register.
// An accepted beat waits in the input register; the parser step is a single registered pass.
// Throughput: one beat per cycle while the result register can take each result.
// A beat that yields no result advances even while the result register is full.
// Reset (aresetn low, synchronous): channels empty, parser hunting, config at defaults.
`default_nettype none

module nfc_response_frame_parser
    import nfcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] timed_out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] payload_byte, [9:8] status, [17:10] frame_length
    output logic             m_tuser,   // [0] is_status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_tmo_reg;
    logic         advance;
    logic         res_valid;
    logic         out_can_load;
    nfcp_result_t res;
    nfcp_cfg_t    cfg;

    // hold the beat while its result cannot be loaded
    assign advance  = in_valid_reg && (!res_valid || out_can_load);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_tmo_reg  <= s_tuser;
        end
    end

    nfcp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nfcp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .rx_byte   (in_byte_reg),
        .timed_out (in_tmo_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    nfcp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res      (res),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: sim/tb_nfc_response_frame_parser.sv
// Self-checking testbench for the NFC response frame parser: directed and random framed traffic vs. a predictor.
module tb_nfc_response_frame_parser;
    import nfcp_pkg::*;

    typedef enum logic [3:0] {
        HUNT0, HUNT1, HUNT2, GET_LEN, GET_LCS, GET_TFI, GET_CMD,
        GET_DATA, GET_DCS, GET_POST, SKIP_CMD
    } parse_phase_e;

    typedef enum int {
        FAULT_NONE, FAULT_PREAMBLE, FAULT_LCS, FAULT_SHORT, FAULT_NOSPACE,
        FAULT_TFI, FAULT_CMD, FAULT_DCS, FAULT_POST, FAULT_TIMEOUT
    } frame_fault_e;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // unmapped register index

    class resp_frame_scoreboard;
        logic [7:0]   sent_command;
        logic [7:0]   max_payload;
        logic [7:0]   direction_code;
        parse_phase_e phase;
        logic [7:0]   length_byte;
        logic [7:0]   remaining;
        logic [7:0]   running_sum;
        nfcp_result_t expected_results[$];
        int           mismatches;
        int           beats_in;
        int           payload_count;
        int           status_count[4];

        function new();
            sent_command   = RST_SENT_COMMAND;
            max_payload    = RST_MAX_PAYLOAD;
            direction_code = RST_DIRECTION_CODE;
            mismatches     = 0;
            beats_in       = 0;
            payload_count  = 0;
            foreach (status_count[i]) status_count[i] = 0;
            go_hunt();
        endfunction

        function void go_hunt();
            phase       = HUNT0;
            length_byte = '0;
            remaining   = '0;
            running_sum = '0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("ERROR: %s", msg);
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_SENT_COMMAND:   sent_command = val;
                CFG_MAX_PAYLOAD:    max_payload = val;
                CFG_DIRECTION_CODE: direction_code = val;
                default: ;
            endcase
        endfunction

        function void push_status(status_t st, logic [7:0] flen);
            nfcp_result_t r;
            r.payload_byte = '0;
            r.is_status    = 1'b1;
            r.status       = st;
            r.frame_length = flen;
            expected_results.push_back(r);
            go_hunt();
        endfunction

        function void note_beat(logic [7:0] b, logic tmo);
            nfcp_result_t r;
            logic [7:0]   pair;
            beats_in++;
            if (tmo) begin
                push_status(ST_TIMEOUT, '0);
                return;
            end
            case (phase)
                HUNT0: begin
                    running_sum = b;
                    phase = HUNT1;
                end
                HUNT1: begin
                    running_sum = running_sum | b;
                    phase = HUNT2;
                end
                HUNT2: begin
                    // whole preamble is judged at its third byte
                    running_sum = running_sum | (b ^ PREAMBLE_LAST);
                    if (running_sum != 8'd0) push_status(ST_INVALID, '0);
                    else begin
                        running_sum = '0;
                        phase = GET_LEN;
                    end
                end
                GET_LEN: begin
                    length_byte = b;
                    phase = GET_LCS;
                end
                GET_LCS: begin
                    pair = length_byte + b;
                    if (pair != 8'd0) push_status(ST_INVALID, '0);
                    else if (length_byte < MIN_LENGTH) push_status(ST_INVALID, '0);
                    else begin
                        remaining = length_byte - MIN_LENGTH;
                        if (remaining > max_payload) push_status(ST_NOSPACE, '0);
                        else phase = GET_TFI;
                    end
                end
                GET_TFI: begin
                    phase = (b == direction_code) ? GET_CMD : SKIP_CMD;
                    running_sum = b;
                end
                SKIP_CMD: push_status(ST_INVALID, '0);
                GET_CMD: begin
                    pair = sent_command + 8'd1;
                    if (b != pair) push_status(ST_INVALID, '0);
                    else begin
                        running_sum = running_sum + b;
                        phase = (remaining == 8'd0) ? GET_DCS : GET_DATA;
                    end
                end
                GET_DATA: begin
                    running_sum = running_sum + b;
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0) phase = GET_DCS;
                    r.payload_byte = b;
                    r.is_status    = 1'b0;
                    r.status       = ST_OK;
                    r.frame_length = '0;
                    expected_results.push_back(r);
                end
                GET_DCS: begin
                    running_sum = running_sum + b;
                    phase = GET_POST;
                end
                GET_POST: begin
                    if (running_sum != 8'd0 || b != 8'd0) push_status(ST_INVALID, '0);
                    else push_status(ST_OK, length_byte - MIN_LENGTH);
                end
                default: go_hunt();
            endcase
        endfunction

        function void check_beat(logic [23:0] data, logic user);
            nfcp_result_t exp_r;
            logic [7:0]   got_byte;
            logic [7:0]   got_len;
            logic [1:0]   got_st;
            got_byte = data[7:0];
            got_st   = data[9:8];
            got_len  = data[17:10];
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result: byte %02h is_status %b status %0d len %0d",
                                 got_byte, user, got_st, got_len));
                return;
            end
            exp_r = expected_results.pop_front();
            if (exp_r.is_status) status_count[exp_r.status]++;
            else payload_count++;
            if (got_byte !== exp_r.payload_byte || user !== exp_r.is_status ||
                got_st !== exp_r.status || got_len !== exp_r.frame_length ||
                data[23:18] !== 6'd0)
                report($sformatf({"expected byte %02h is_status %b status %s len %0d, ",
                                  "got byte %02h is_status %b status %0d len %0d pad %02h"},
                                 exp_r.payload_byte, exp_r.is_status, exp_r.status.name(),
                                 exp_r.frame_length, got_byte, user, got_st, got_len,
                                 data[23:18]));
        endfunction

        function void close_out();
            while (expected_results.size() > 0) begin
                void'(expected_results.pop_front());
                report("expected result never arrived");
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    resp_frame_scoreboard sb = new();
    bit quiet = 1'b0;
    int hold_request = 0;
    int stall_left = 0;

    nfc_response_frame_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(logic [7:0] rx, logic tmo);
        int gap;
        gap = idle_len();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        s_tuser  <= tmo;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(rx, tmo);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every expected result is out and the pipe is empty.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.expected_results.size() > 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_regs(logic [7:0] cmd, logic [7:0] maxp, logic [7:0] dir, bit spare);
        logic [7:0] vals[4];
        vals = '{cmd, maxp, dir, 8'($urandom_range(0, 255))};
        for (int i = 0; i < 4; i++) begin
            if (i == CFG_SPARE && !spare) break;
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(2'(i), vals[i]);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_frame(int plen, frame_fault_e fault);
        logic [7:0] bytes[$];
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] flip;
        int         cut;
        int         tmo_at;
        // start each frame from hunting; a timeout beat forces it
        if (sb.phase != HUNT0) send_item(8'($urandom_range(0, 255)), 1'b1);
        len  = 8'(plen + 2);
        sum  = sb.direction_code + sb.sent_command + 8'd1;
        flip = 8'($urandom_range(1, 255));
        bytes = '{8'h00, 8'h00, PREAMBLE_LAST, len, 8'd0 - len, sb.direction_code,
                  sb.sent_command + 8'd1};
        for (int i = 0; i < plen; i++) begin
            bytes.push_back(8'($urandom_range(0, 255)));
            sum = sum + bytes[$];
        end
        bytes.push_back(8'd0 - sum);
        bytes.push_back(8'h00);
        cut = bytes.size();
        tmo_at = -1;
        case (fault)
            FAULT_PREAMBLE: begin
                bytes[$urandom_range(0, 2)] ^= flip;
                cut = 3;
            end
            FAULT_LCS: begin
                bytes[4] ^= flip;
                cut = 5;
            end
            FAULT_SHORT: begin
                // length 0 or 1 with a matching checksum
                bytes[3] = 8'(plen & 1);
                bytes[4] = 8'd0 - bytes[3];
                cut = 5;
            end
            FAULT_NOSPACE: cut = 5;
            FAULT_TFI: begin
                bytes[5] ^= flip;
                cut = 7;
            end
            FAULT_CMD: begin
                bytes[6] ^= flip;
                cut = 7;
            end
            FAULT_DCS:  bytes[7 + plen] ^= flip;
            FAULT_POST: bytes[8 + plen] ^= flip;
            FAULT_TIMEOUT: begin
                tmo_at = $urandom_range(0, bytes.size() - 1);
                cut = tmo_at + 1;
            end
            default: ;
        endcase
        for (int i = 0; i < cut; i++) send_item(bytes[i], i == tmo_at);
    endtask

    task automatic random_frame();
        int           r;
        int           plen;
        int           maxp;
        frame_fault_e fault;
        r = $urandom_range(0, 99);
        maxp = sb.max_payload;
        if (r >= 93) begin
            // line noise, biased toward preamble-like bytes
            repeat ($urandom_range(1, 7)) begin
                if ($urandom_range(0, 2) == 0)
                    send_item($urandom_range(0, 1) ? PREAMBLE_LAST : 8'h00,
                              $urandom_range(0, 19) == 0);
                else
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end
            return;
        end
        if (maxp == 0) plen = 0;
        else if ($urandom_range(0, 4) != 0) plen = $urandom_range(0, (maxp < 12) ? maxp : 12);
        else plen = $urandom_range(0, maxp);
        fault = (r < 62) ? FAULT_NONE : frame_fault_e'($urandom_range(1, 9));
        if (fault == FAULT_NOSPACE) begin
            if (maxp >= 253) fault = FAULT_SHORT;
            else plen = $urandom_range(maxp + 1, 253);
        end
        send_frame(plen, fault);
    endtask

    // result side: random stalls, plus long hold-offs on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_len() > 0) begin
                m_tready <= 1'b0;
                stall_left = idle_len();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d results still expected", sb.expected_results.size());
        $display("nfc_response_frame_parser: mismatch");
        $finish;
    end

    initial begin
        int random_start;
        int phase_start;
        int r;
        logic [7:0] cmd;
        logic [7:0] maxp;
        logic [7:0] dir;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: defaults, every status and check order
        send_item(8'hA5, 1'b1);
        send_frame(0, FAULT_NONE);
        send_frame(3, FAULT_NONE);
        send_frame(2, FAULT_PREAMBLE);
        send_frame(2, FAULT_LCS);
        send_frame(0, FAULT_SHORT);
        send_frame(1, FAULT_SHORT);
        send_frame(65, FAULT_NOSPACE);
        send_frame(2, FAULT_TFI);
        send_frame(2, FAULT_CMD);
        send_frame(4, FAULT_DCS);
        send_frame(4, FAULT_POST);
        send_frame(5, FAULT_TIMEOUT);
        wait_drain();

        // extremes: command wraps, largest payload, spare index ignored
        write_regs(8'hFF, 8'hFF, 8'h00, 1'b1);
        send_frame(253, FAULT_NONE);
        send_frame(252, FAULT_NONE);
        // long receiver hold-off while the sender keeps pushing
        quiet = 1'b1;
        hold_request = 250;
        send_frame(220, FAULT_NONE);
        quiet = 1'b0;
        wait_drain();
        write_regs(8'h00, 8'h00, 8'hFF, 1'b0);
        send_frame(0, FAULT_NONE);
        send_frame(1, FAULT_NOSPACE);
        send_frame(253, FAULT_NOSPACE);
        wait_drain();

        random_start = sb.beats_in;
        while (sb.beats_in - random_start < 450) begin
            r = $urandom_range(0, 99);
            cmd  = (r < 15) ? 8'hFF : (r < 30) ? 8'h00 : 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            maxp = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : (r < 30) ? 8'd253 :
                   (r < 75) ? 8'($urandom_range(1, 40)) : 8'($urandom_range(0, 255));
            dir  = $urandom_range(0, 1) ? RST_DIRECTION_CODE : 8'($urandom_range(0, 255));
            write_regs(cmd, maxp, dir, $urandom_range(0, 3) == 0);
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) hold_request = $urandom_range(40, 120);
            phase_start = sb.beats_in;
            while (sb.beats_in - phase_start < 150 && sb.beats_in - random_start < 450)
                random_frame();
            quiet = 1'b0;
            wait_drain();
        end

        sb.close_out();
        $display("covered %0d input beats over several register settings", sb.beats_in);
        $display("results: %0d payload bytes, ok %0d, timeout %0d, invalid %0d, no space %0d",
                 sb.payload_count, sb.status_count[ST_OK], sb.status_count[ST_TIMEOUT],
                 sb.status_count[ST_INVALID], sb.status_count[ST_NOSPACE]);
        if (sb.mismatches == 0) begin
            $display("nfc_response_frame_parser: match");
        end else begin
            $display("nfc_response_frame_parser: mismatch");
        end
        $finish;
    end
endmodule
